[rtl/sm83_pkg.sv]
package sm83_pkg;

   typedef enum logic [4:0] {
      ACT_ADD8  = 5'd0,
      ACT_ADC8  = 5'd1,
      ACT_SUB8  = 5'd2,
      ACT_SBC8  = 5'd3,
      ACT_AND   = 5'd4,
      ACT_OR    = 5'd5,
      ACT_XOR   = 5'd6,
      ACT_CP    = 5'd7,
      ACT_INC8  = 5'd8,
      ACT_DEC8  = 5'd9,
      ACT_ADD16 = 5'd10,
      ACT_ADDSP = 5'd11,
      ACT_DAA   = 5'd12,
      ACT_CPL   = 5'd13,
      ACT_CCF   = 5'd14,
      ACT_SCF   = 5'd15,
      ACT_RLA   = 5'd16,
      ACT_RLCA  = 5'd17,
      ACT_RRA   = 5'd18,
      ACT_RRCA  = 5'd19,
      ACT_INC16 = 5'd20,
      ACT_DEC16 = 5'd21
   } action_type;

   localparam int unsigned FLAG_Z = 3;
   localparam int unsigned FLAG_N = 2;
   localparam int unsigned FLAG_H = 1;
   localparam int unsigned FLAG_C = 0;

   localparam logic [7:0] DAA_LIMIT  = 8'h99;
   localparam logic [7:0] DAA_HIGH   = 8'h60;
   localparam logic [7:0] DAA_LOW    = 8'h06;
   localparam logic [3:0] DAA_DIGIT  = 4'h9;

   typedef struct packed {
      logic [4:0]  action;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [3:0]  flags_in;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] result;
      logic [3:0]  flags_out;
      logic        write_back;
   } rsp_payload_type;

endpackage

[rtl/sm83_req_if.sv]
interface sm83_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  action;
   logic [15:0] operand_a;
   logic [15:0] operand_b;
   logic [3:0]  flags_in;

   modport source (output valid, output action, output operand_a, output operand_b,
                   output flags_in, input ready);
   modport sink (input valid, input action, input operand_a, input operand_b,
                 input flags_in, output ready);
endinterface

[rtl/sm83_rsp_if.sv]
interface sm83_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] result;
   logic [3:0]  flags_out;
   logic        write_back;

   modport source (output valid, output result, output flags_out, output write_back,
                   input ready);
   modport sink (input valid, input result, input flags_out, input write_back,
                 output ready);
endinterface

[rtl/sm83_alu.sv]
module sm83_alu import sm83_pkg::*; (
   input  req_payload_type op,
   output rsp_payload_type res
);

   logic [7:0]  a;
   logic [7:0]  b;
   logic        cin;
   logic        use_carry;
   logic [8:0]  sum8;
   logic [4:0]  sum_nib;
   logic [8:0]  diff8;
   logic [4:0]  diff_nib;
   logic [16:0] sum16;
   logic [12:0] sum12;
   logic [15:0] sp_sum;
   logic [4:0]  sp_nib;
   logic [8:0]  sp_byte;
   logic [7:0]  inc8;
   logic [7:0]  dec8;
   logic        daa_high;
   logic        daa_low;
   logic [7:0]  daa_val;

   assign a   = op.operand_a[7:0];
   assign b   = op.operand_b[7:0];
   assign cin = op.flags_in[FLAG_C];
   assign use_carry = ((op.action == ACT_ADC8) || (op.action == ACT_SBC8)) && cin;

   assign sum8     = {1'b0, a} + {1'b0, b} + {8'd0, use_carry};
   assign sum_nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, use_carry};
   assign diff8    = {1'b0, a} - {1'b0, b} - {8'd0, use_carry};
   assign diff_nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, use_carry};
   assign sum16    = {1'b0, op.operand_a} + {1'b0, op.operand_b};
   assign sum12    = {1'b0, op.operand_a[11:0]} + {1'b0, op.operand_b[11:0]};
   assign sp_sum   = op.operand_a + {{8{b[7]}}, b};
   assign sp_nib   = {1'b0, op.operand_a[3:0]} + {1'b0, b[3:0]};
   assign sp_byte  = {1'b0, op.operand_a[7:0]} + {1'b0, b};
   assign inc8     = a + 8'd1;
   assign dec8     = a - 8'd1;

   // decimal adjust
   always_comb begin
      daa_val  = a;
      daa_high = cin;
      daa_low  = op.flags_in[FLAG_H];
      if (!op.flags_in[FLAG_N]) begin
         daa_high = cin || (a > DAA_LIMIT);
         daa_low  = op.flags_in[FLAG_H] || (a[3:0] > DAA_DIGIT);
         daa_val  = a + (daa_high ? DAA_HIGH : 8'd0) + (daa_low ? DAA_LOW : 8'd0);
      end else begin
         daa_val  = a - (daa_high ? DAA_HIGH : 8'd0) - (daa_low ? DAA_LOW : 8'd0);
      end
   end

   always_comb begin
      res.result     = 16'd0;
      res.flags_out  = op.flags_in;
      res.write_back = 1'b1;
      case (op.action)
         ACT_ADD8, ACT_ADC8: begin
            res.result    = {8'd0, sum8[7:0]};
            res.flags_out = {sum8[7:0] == 8'd0, 1'b0, sum_nib[4], sum8[8]};
         end
         ACT_SUB8, ACT_SBC8: begin
            res.result    = {8'd0, diff8[7:0]};
            res.flags_out = {diff8[7:0] == 8'd0, 1'b1, diff_nib[4], diff8[8]};
         end
         ACT_CP: begin
            res.flags_out  = {diff8[7:0] == 8'd0, 1'b1, diff_nib[4], diff8[8]};
            res.write_back = 1'b0;
         end
         ACT_AND: begin
            res.result    = {8'd0, a & b};
            res.flags_out = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
         end
         ACT_OR: begin
            res.result    = {8'd0, a | b};
            res.flags_out = {(a | b) == 8'd0, 3'b000};
         end
         ACT_XOR: begin
            res.result    = {8'd0, a ^ b};
            res.flags_out = {(a ^ b) == 8'd0, 3'b000};
         end
         ACT_INC8: begin
            res.result    = {8'd0, inc8};
            res.flags_out = {inc8 == 8'd0, 1'b0, a[3:0] == 4'hF, cin};
         end
         ACT_DEC8: begin
            res.result    = {8'd0, dec8};
            res.flags_out = {dec8 == 8'd0, 1'b1, a[3:0] == 4'h0, cin};
         end
         ACT_ADD16: begin
            res.result    = sum16[15:0];
            res.flags_out = {op.flags_in[FLAG_Z], 1'b0, sum12[12], sum16[16]};
         end
         ACT_ADDSP: begin
            res.result    = sp_sum;
            res.flags_out = {2'b00, sp_nib[4], sp_byte[8]};
         end
         ACT_DAA: begin
            res.result    = {8'd0, daa_val};
            res.flags_out = {daa_val == 8'd0, op.flags_in[FLAG_N], 1'b0, daa_high};
         end
         ACT_CPL: begin
            res.result    = {8'd0, ~a};
            res.flags_out = {op.flags_in[FLAG_Z], 2'b11, cin};
         end
         ACT_CCF: begin
            res.flags_out  = {op.flags_in[FLAG_Z], 2'b00, !cin};
            res.write_back = 1'b0;
         end
         ACT_SCF: begin
            res.flags_out  = {op.flags_in[FLAG_Z], 3'b001};
            res.write_back = 1'b0;
         end
         ACT_RLA: begin
            res.result    = {8'd0, a[6:0], cin};
            res.flags_out = {3'b000, a[7]};
         end
         ACT_RLCA: begin
            res.result    = {8'd0, a[6:0], a[7]};
            res.flags_out = {3'b000, a[7]};
         end
         ACT_RRA: begin
            res.result    = {8'd0, cin, a[7:1]};
            res.flags_out = {3'b000, a[0]};
         end
         ACT_RRCA: begin
            res.result    = {8'd0, a[0], a[7:1]};
            res.flags_out = {3'b000, a[0]};
         end
         ACT_INC16: begin
            res.result = op.operand_a + 16'd1;
         end
         ACT_DEC16: begin
            res.result = op.operand_a - 16'd1;
         end
         default: begin
            res.write_back = 1'b0;
         end
      endcase
   end

endmodule

[rtl/sm83_alu_flags.sv]
// an accepted request reaches its response through the input register, then the
// result register
// throughput: one transaction per cycle while rsp.ready keeps the output moving; the
// single-pass alu between the two registers sets this figure
// reset: synchronous active-high reset empties both stages; req.ready is low during reset
module sm83_alu_flags import sm83_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   sm83_req_if.sink      req,
   sm83_rsp_if.source    rsp
);

   logic            s1_valid_ff;
   logic            s1_valid_in;
   req_payload_type s1_data_ff;
   req_payload_type s1_data_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type alu_out;
   logic            s1_open;
   logic            s2_open;
   logic            req_take;

   assign s2_open   = !rsp_valid_ff || rsp.ready;
   assign s1_open   = !s1_valid_ff || s2_open;
   assign req.ready = !reset && s1_open;
   assign req_take  = req.valid && req.ready;

   assign s1_data_in = '{action: req.action, operand_a: req.operand_a,
                         operand_b: req.operand_b, flags_in: req.flags_in};

   assign s1_valid_in  = s1_open ? req_take : s1_valid_ff;
   assign rsp_valid_in = s2_open ? s1_valid_ff : rsp_valid_ff;

   sm83_alu u_alu (
      .op  (s1_data_ff),
      .res (alu_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= s1_data_in;
      end
      if (s2_open && s1_valid_ff) begin
         rsp_data_ff <= alu_out;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.result     = rsp_data_ff.result;
   assign rsp.flags_out  = rsp_data_ff.flags_out;
   assign rsp.write_back = rsp_data_ff.write_back;

endmodule

[rtl/sm83_alu_flags_checker.sv]
module sm83_alu_flags_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_result,
   input logic [3:0]  rsp_flags_out,
   input logic        rsp_write_back
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result)
         && $stable(rsp_flags_out) && $stable(rsp_write_back))
      else $error("stalled response changed");

   // accepted transaction reaches the output through the input and result registers when the sink keeps up
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready ##1 rsp_ready |=> rsp_valid)
      else $error("response missing after two cycles");

   // no write back means no result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_back |-> rsp_result == 16'd0)
      else $error("nonzero result without write back");

   // an empty output never blocks the input
   assert property (@(posedge clock) disable iff (reset)
      !reset && !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

endmodule

bind sm83_alu_flags sm83_alu_flags_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_result     (rsp.result),
   .rsp_flags_out  (rsp.flags_out),
   .rsp_write_back (rsp.write_back)
);

[verif/sm83_alu_flags_tb.sv]
`timescale 1ns / 1ps

module sm83_alu_flags_tb;
   import sm83_pkg::*;

   localparam int unsigned RANDOM_OPS = 1000;
   localparam int unsigned PHASE_LEN = 150;

   localparam int unsigned PHASE_FREE = 0;
   localparam int unsigned PHASE_SEND_IDLE = 1;
   localparam int unsigned PHASE_STALL = 2;
   localparam int unsigned PHASE_BOTH = 3;

   // codes past the last defined operation
   localparam logic [4:0] ACT_FIRST_UNUSED = 5'd22;
   localparam logic [4:0] ACT_LAST_UNUSED = 5'd31;

   logic clock;
   logic reset;

   sm83_req_if req_ch ();
   sm83_rsp_if rsp_ch ();

   req_payload_type pending_ops[$];
   rsp_payload_type expected_rsp[$];
   int unsigned error_count = 0;
   int unsigned accepted_count = 0;

   sm83_alu_flags uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rsp_payload_type alu_outcome(req_payload_type op);
      rsp_payload_type res;
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] r8;
      logic [15:0] sp_ofs;
      logic [16:0] sum17;
      logic [12:0] sum13;
      logic [8:0] sum9;
      logic [4:0] sum5;
      logic cin;
      logic carry;
      logic [3:0] f;
      logic [3:0] nf;
      a = op.operand_a[7:0];
      b = op.operand_b[7:0];
      f = op.flags_in;
      cin = f[FLAG_C];
      nf = f;
      r8 = 8'h00;
      res.result = 16'h0000;
      res.write_back = 1'b1;
      case (op.action)
         ACT_ADD8, ACT_ADC8: begin
            carry = (op.action == ACT_ADC8) ? cin : 1'b0;
            sum9 = {1'b0, a} + {1'b0, b} + {8'h00, carry};
            sum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, carry};
            r8 = sum9[7:0];
            nf = 4'h0;
            nf[FLAG_Z] = (r8 == 8'h00);
            nf[FLAG_H] = sum5[4];
            nf[FLAG_C] = sum9[8];
            res.result = {8'h00, r8};
         end
         ACT_SUB8, ACT_SBC8, ACT_CP: begin
            carry = (op.action == ACT_SBC8) ? cin : 1'b0;
            r8 = a - b - {7'h00, carry};
            nf = 4'h0;
            nf[FLAG_Z] = (r8 == 8'h00);
            nf[FLAG_N] = 1'b1;
            nf[FLAG_H] = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'h0, carry});
            nf[FLAG_C] = {1'b0, a} < ({1'b0, b} + {8'h00, carry});
            if (op.action == ACT_CP) begin
               res.write_back = 1'b0;
            end else begin
               res.result = {8'h00, r8};
            end
         end
         ACT_AND, ACT_OR, ACT_XOR: begin
            if (op.action == ACT_AND) r8 = a & b;
            else if (op.action == ACT_OR) r8 = a | b;
            else r8 = a ^ b;
            nf = 4'h0;
            nf[FLAG_Z] = (r8 == 8'h00);
            nf[FLAG_H] = (op.action == ACT_AND);
            res.result = {8'h00, r8};
         end
         ACT_INC8, ACT_DEC8: begin
            r8 = (op.action == ACT_INC8) ? a + 8'd1 : a - 8'd1;
            nf[FLAG_Z] = (r8 == 8'h00);
            nf[FLAG_N] = (op.action == ACT_DEC8);
            nf[FLAG_H] = (op.action == ACT_INC8) ? (a[3:0] == 4'hF) : (a[3:0] == 4'h0);
            res.result = {8'h00, r8};
         end
         ACT_ADD16: begin
            sum17 = {1'b0, op.operand_a} + {1'b0, op.operand_b};
            sum13 = {1'b0, op.operand_a[11:0]} + {1'b0, op.operand_b[11:0]};
            nf[FLAG_N] = 1'b0;
            nf[FLAG_H] = sum13[12];
            nf[FLAG_C] = sum17[16];
            res.result = sum17[15:0];
         end
         ACT_ADDSP: begin
            sp_ofs = {{8{b[7]}}, b};
            sum9 = {1'b0, op.operand_a[7:0]} + {1'b0, b};
            sum5 = {1'b0, op.operand_a[3:0]} + {1'b0, b[3:0]};
            nf = 4'h0;
            nf[FLAG_H] = sum5[4];
            nf[FLAG_C] = sum9[8];
            res.result = op.operand_a + sp_ofs;
         end
         ACT_DAA: begin
            carry = cin;
            r8 = a;
            if (!f[FLAG_N]) begin
               if (carry || r8 > 8'h99) begin
                  r8 = r8 + 8'h60;
                  carry = 1'b1;
               end
               if (f[FLAG_H] || r8[3:0] > 4'h9) r8 = r8 + 8'h06;
            end else begin
               if (carry) r8 = r8 - 8'h60;
               if (f[FLAG_H]) r8 = r8 - 8'h06;
            end
            nf[FLAG_Z] = (r8 == 8'h00);
            nf[FLAG_H] = 1'b0;
            nf[FLAG_C] = carry;
            res.result = {8'h00, r8};
         end
         ACT_CPL: begin
            nf[FLAG_N] = 1'b1;
            nf[FLAG_H] = 1'b1;
            res.result = {8'h00, ~a};
         end
         ACT_CCF, ACT_SCF: begin
            nf[FLAG_N] = 1'b0;
            nf[FLAG_H] = 1'b0;
            nf[FLAG_C] = (op.action == ACT_SCF) ? 1'b1 : ~cin;
            res.write_back = 1'b0;
         end
         ACT_RLA, ACT_RLCA, ACT_RRA, ACT_RRCA: begin
            case (op.action)
               ACT_RLA:  r8 = {a[6:0], cin};
               ACT_RLCA: r8 = {a[6:0], a[7]};
               ACT_RRA:  r8 = {cin, a[7:1]};
               default:  r8 = {a[0], a[7:1]};
            endcase
            nf = 4'h0;
            nf[FLAG_C] = (op.action == ACT_RLA || op.action == ACT_RLCA) ? a[7] : a[0];
            res.result = {8'h00, r8};
         end
         ACT_INC16: res.result = op.operand_a + 16'd1;
         ACT_DEC16: res.result = op.operand_a - 16'd1;
         default: res.write_back = 1'b0;
      endcase
      res.flags_out = nf;
      return res;
   endfunction

   function automatic int unsigned current_phase();
      return (accepted_count / PHASE_LEN) % 4;
   endfunction

   function automatic int unsigned sender_gap_pct();
      case (current_phase())
         PHASE_FREE:      return 0;
         PHASE_SEND_IDLE: return 69;
         PHASE_BOTH:      return 6;
         default:         return 0;
      endcase
   endfunction

   function automatic int unsigned receiver_stall_pct();
      case (current_phase())
         PHASE_FREE:  return 0;
         PHASE_STALL: return 69;
         PHASE_BOTH:  return 6;
         default:     return 0;
      endcase
   endfunction

   function automatic logic [15:0] pick_word();
      logic [15:0] corners[8];
      corners = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h8000, 16'h7FFF,
                  16'h000F, 16'h0FFF};
      if ($urandom_range(7) == 0) return corners[$urandom_range(7)];
      return 16'($urandom);
   endfunction

   task automatic queue_op(logic [4:0] act, logic [15:0] a, logic [15:0] b, logic [3:0] f);
      req_payload_type op;
      op.action = act;
      op.operand_a = a;
      op.operand_b = b;
      op.flags_in = f;
      pending_ops.push_back(op);
   endtask

   // driver: holds each transaction until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_rsp.push_back(alu_outcome(pending_ops.pop_front()));
            accepted_count++;
         end
         if (!(req_ch.valid && !req_ch.ready)) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= sender_gap_pct()) begin
               req_ch.valid <= 1'b1;
               req_ch.action <= pending_ops[0].action;
               req_ch.operand_a <= pending_ops[0].operand_a;
               req_ch.operand_b <= pending_ops[0].operand_b;
               req_ch.flags_in <= pending_ops[0].flags_in;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp.size() == 0) begin
               $error("response with no transaction outstanding");
               error_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_ch.result !== want.result) begin
                  $error("result: expected %h, got %h", want.result, rsp_ch.result);
                  error_count++;
               end
               if (rsp_ch.flags_out !== want.flags_out) begin
                  $error("flags_out: expected %b, got %b", want.flags_out, rsp_ch.flags_out);
                  error_count++;
               end
               if (rsp_ch.write_back !== want.write_back) begin
                  $error("write_back: expected %b, got %b", want.write_back,
                         rsp_ch.write_back);
                  error_count++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct());
      end
   end

   initial begin
      int unsigned counted;
      logic [4:0] act;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.action = '0;
      req_ch.operand_a = '0;
      req_ch.operand_b = '0;
      req_ch.flags_in = '0;
      rsp_ch.ready = 1'b0;

      // every operation at one extreme: even codes with all ones, odd codes with all zeros
      for (int i = 0; i <= ACT_DEC16; i++) begin
         if (i % 2 == 0) queue_op(5'(i), 16'hFFFF, 16'hFFFF, 4'hF);
         else queue_op(5'(i), 16'h0000, 16'h0000, 4'h0);
      end
      queue_op(ACT_LAST_UNUSED, 16'hFFFF, 16'hFFFF, 4'hF);
      queue_op(ACT_FIRST_UNUSED, 16'h1234, 16'h5678, 4'h5);
      queue_op(ACT_INC16, 16'hFFFF, 16'h0000, 4'h0);
      queue_op(ACT_DEC16, 16'h0000, 16'h0000, 4'hF);
      queue_op(ACT_DAA, 16'h009A, 16'h0000, 4'h0);
      queue_op(ACT_ADDSP, 16'hFFF8, 16'h0080, 4'hF);

      counted = 0;
      while (counted < RANDOM_OPS) begin
         if ($urandom_range(19) == 0) begin
            act = 5'($urandom_range(ACT_LAST_UNUSED, ACT_FIRST_UNUSED));
         end else begin
            act = 5'($urandom_range(ACT_DEC16, 0));
            counted++;
         end
         queue_op(act, pick_word(), pick_word(), 4'($urandom_range(15)));
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0) @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Verification failed");
      $finish;
   end

endmodule
